/* hdl/toroidal_life_automaton_top_macros.svh */
// Assertion macros for the toroidal life automaton checker.
// Needs a clk and an rst_n in the scope where a macro is used.
`ifndef TOROIDAL_LIFE_AUTOMATON_TOP_MACROS_SVH
`define TOROIDAL_LIFE_AUTOMATON_TOP_MACROS_SVH

// same-cycle implication
`define TLA_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tla check failed");

// next-cycle implication
`define TLA_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tla check failed");

`endif

/* hdl/tla_pkg.sv */
// Shared types and constants for the toroidal life automaton.
// No dependencies.
package tla_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 256;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  localparam int KIND_W     = 2;
  localparam int ROWS_REG_W = 7;
  localparam int COLS_REG_W = 9;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int NCNT_W     = 4;

  localparam logic [NCNT_W-1:0] SURVIVE_CNT = NCNT_W'(2);
  localparam logic [NCNT_W-1:0] BIRTH_CNT   = NCNT_W'(3);

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef logic [MAX_COLS-1:0] row_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_ADV_LAST,
    ST_ADV_ZERO,
    ST_ADV_ONE,
    ST_ADV_RUN
  } state_t;

endpackage

/* hdl/toroidal_life_automaton_top.sv */
// Top level of the toroidal life automaton: sequencer, size registers, grid RAM.
// Depends on tla_pkg, tla_ram and tla_row_unit.
//
//  channel  | handshake        | word
//  ---------+------------------+-------------------------------------------
//  input    | start, busy      | in_kind, in_row, in_col, in_cell_value
//  result   | out_valid strobe | out_read_value, out_accepted
//  config   | cfg_we           | cfg_index, cfg_data
//
// Read and write: a RAM read, then the result or a read-modify-write.
// Ignored item: result in the next cycle, no busy time.
// Advance: busy reading the last row, row 0 and row 1, then one row a cycle
// through the shared row unit on the single RAM port pair, then the result.
// Reset clears the grid at once by per-row valid flags; no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
module toroidal_life_automaton_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tla_pkg::KIND_W-1:0]     in_kind,
  input  logic [tla_pkg::ROW_W-1:0]      in_row,
  input  logic [tla_pkg::COL_W-1:0]      in_col,
  input  logic                           in_cell_value,
  output logic                           out_valid,
  output logic                           out_read_value,
  output logic                           out_accepted,
  input  logic                           cfg_we,
  input  logic [tla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tla_pkg::CFG_W-1:0]      cfg_data
);
  import tla_pkg::*;

  state_t              state_r, state_nxt;
  logic [RCNT_W-1:0]   rows_r;
  logic [CCNT_W-1:0]   cols_r;
  logic [MAX_ROWS-1:0] vld_r;
  logic                rvld_r;
  logic [ROW_W-1:0]    ridx_r, ridx_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic                val_r, val_nxt;
  row_word_t           up_r, up_nxt, mid_r, mid_nxt, row0_r, row0_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_rd_r, out_rd_nxt;
  logic                out_acc_r, out_acc_nxt;

  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr, ram_raddr, last_row;
  row_word_t           ram_wdata, ram_rdata, rd_eff, down, new_row;
  logic                accept, in_range;

  logic [ROWS_REG_W-1:0] cfg_rows_v;
  logic [COLS_REG_W-1:0] cfg_cols_v;
  logic [RCNT_W-1:0]     rows_clamp;
  logic [CCNT_W-1:0]     cols_clamp;

  assign cfg_rows_v = cfg_data[ROWS_REG_W-1:0];
  assign cfg_cols_v = cfg_data[COLS_REG_W-1:0];

  always_comb begin
    if (cfg_rows_v == '0) begin
      rows_clamp = RCNT_W'(1);
    end else if (32'(cfg_rows_v) > MAX_ROWS) begin
      rows_clamp = RCNT_W'(MAX_ROWS);
    end else begin
      rows_clamp = RCNT_W'(cfg_rows_v);
    end
    if (cfg_cols_v == '0) begin
      cols_clamp = CCNT_W'(1);
    end else if (32'(cfg_cols_v) > MAX_COLS) begin
      cols_clamp = CCNT_W'(MAX_COLS);
    end else begin
      cols_clamp = CCNT_W'(cfg_cols_v);
    end
  end

  tla_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_eff   = rvld_r ? ram_rdata : '0;
  assign last_row = ROW_W'(rows_r - RCNT_W'(1));
  assign down     = (ridx_r == last_row) ? row0_r : rd_eff;

  tla_row_unit u_rule (
    .up      (up_r),
    .mid     (mid_r),
    .down    (down),
    .cols    (cols_r),
    .new_row (new_row)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (RCNT_W'(in_row) < rows_r) && (CCNT_W'(in_col) < cols_r);

  always_comb begin
    state_nxt     = state_r;
    ridx_nxt      = ridx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    row0_nxt      = row0_r;
    out_valid_nxt = 1'b0;
    out_rd_nxt    = 1'b0;
    out_acc_nxt   = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = row_r;
    ram_wdata     = rd_eff;
    ram_raddr     = in_row;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          row_nxt = in_row;
          col_nxt = in_col;
          val_nxt = in_cell_value;
          if (in_kind == KIND_ADVANCE) begin
            state_nxt = ST_ADV_LAST;
          end else if (in_range && (in_kind == KIND_READ)) begin
            state_nxt = ST_RD;
          end else if (in_range && (in_kind == KIND_WRITE)) begin
            state_nxt = ST_WR;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        out_valid_nxt = 1'b1;
        out_acc_nxt   = 1'b1;
        out_rd_nxt    = rd_eff[col_r];
        state_nxt     = ST_IDLE;
      end
      ST_WR: begin
        ram_we             = 1'b1;
        ram_wdata[col_r]   = val_r;
        out_valid_nxt      = 1'b1;
        out_acc_nxt        = 1'b1;
        state_nxt          = ST_IDLE;
      end
      ST_ADV_LAST: begin
        ram_raddr = last_row;
        state_nxt = ST_ADV_ZERO;
      end
      ST_ADV_ZERO: begin
        ram_raddr = '0;
        up_nxt    = rd_eff;
        state_nxt = ST_ADV_ONE;
      end
      ST_ADV_ONE: begin
        ram_raddr = ROW_W'(1);
        mid_nxt   = rd_eff;
        row0_nxt  = rd_eff;
        ridx_nxt  = '0;
        state_nxt = ST_ADV_RUN;
      end
      ST_ADV_RUN: begin
        ram_raddr = ridx_r + ROW_W'(2);
        ram_we    = 1'b1;
        ram_waddr = ridx_r;
        ram_wdata = new_row;
        up_nxt    = mid_r;
        mid_nxt   = down;
        ridx_nxt  = ridx_r + ROW_W'(1);
        if (ridx_r == last_row) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= RCNT_W'(MAX_ROWS);
      cols_r      <= CCNT_W'(MAX_COLS);
      vld_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rvld_r      <= vld_r[ram_raddr];
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (cfg_we && (cfg_index == CFG_ROWS)) begin
        rows_r <= rows_clamp;
      end
      if (cfg_we && (cfg_index == CFG_COLS)) begin
        cols_r <= cols_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r    <= ridx_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    val_r     <= val_nxt;
    up_r      <= up_nxt;
    mid_r     <= mid_nxt;
    row0_r    <= row0_nxt;
    out_rd_r  <= out_rd_nxt;
    out_acc_r <= out_acc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_accepted   = out_acc_r;

endmodule

/* hdl/tla_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tla_row_unit.sv */
// B3/S23 update of one grid row from the rows above, at and below it.
// Depends on tla_pkg. Columns at or past the in-use width keep their value.
module tla_row_unit (
  input  tla_pkg::row_word_t               up,
  input  tla_pkg::row_word_t               mid,
  input  tla_pkg::row_word_t               down,
  input  logic [tla_pkg::CCNT_W-1:0]       cols,
  output tla_pkg::row_word_t               new_row
);
  import tla_pkg::*;

  logic [COL_W-1:0] last_col;
  logic             up_last, mid_last, down_last;

  assign last_col  = COL_W'(cols - CCNT_W'(1));
  assign up_last   = up[last_col];
  assign mid_last  = mid[last_col];
  assign down_last = down[last_col];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    logic ul, ml, dl, ur, mr, dr;
    logic             at_end;
    logic [NCNT_W-1:0] cnt;

    assign at_end = (last_col == COL_W'(c));

    if (c == 0) begin : g_left_wrap
      assign ul = up_last;
      assign ml = mid_last;
      assign dl = down_last;
    end else begin : g_left
      assign ul = up[c-1];
      assign ml = mid[c-1];
      assign dl = down[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_wrap
      assign ur = up[0];
      assign mr = mid[0];
      assign dr = down[0];
    end else begin : g_right
      assign ur = at_end ? up[0]   : up[c+1];
      assign mr = at_end ? mid[0]  : mid[c+1];
      assign dr = at_end ? down[0] : down[c+1];
    end

    assign cnt = NCNT_W'(ul) + NCNT_W'(up[c]) + NCNT_W'(ur) + NCNT_W'(ml)
               + NCNT_W'(mr) + NCNT_W'(dl) + NCNT_W'(down[c]) + NCNT_W'(dr);

    always_comb begin
      if (CCNT_W'(c) >= cols) begin
        new_row[c] = mid[c];
      end else if (mid[c]) begin
        new_row[c] = (cnt == SURVIVE_CNT) || (cnt == BIRTH_CNT);
      end else begin
        new_row[c] = (cnt == BIRTH_CNT);
      end
    end
  end

endmodule

/* hdl/tla_checker.sv */
// Port-level checks for the toroidal life automaton, bound to the top level.
// Depends on toroidal_life_automaton_top_macros.svh.
`include "toroidal_life_automaton_top_macros.svh"

module tla_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic                           out_read_value,
  input logic                           out_accepted
);

  // a word leaves only once the sequencer is back at rest
  `TLA_CHK_SAME(a_out_idle, out_valid, !busy)
  // every accepted word either answers at once or keeps the block busy
  `TLA_CHK_NEXT(a_accept_moves, start && !busy, out_valid || busy)
  // the end of a busy spell always carries its result
  `TLA_CHK_SAME(a_busy_end_result, $fell(busy), out_valid)
  // an ignored word never reports a live cell
  `TLA_CHK_SAME(a_read_needs_acc, out_valid && out_read_value, out_accepted)

endmodule

bind toroidal_life_automaton_top tla_checker u_tla_checker (.*);
